FILE: rtl/mte_pkg.sv
package mte_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_TAPS_W     = 3;
    localparam int CFG_SPACING_W  = 15;
    localparam int CFG_RING_W     = 15;
    localparam int GAIN_W         = 16;
    localparam int NUM_GAINS      = 4;

    localparam int DEF_RING_DEPTH = 16384;
    localparam int DEF_MAX_TAPS   = 4;

    // One remainder step per bit of the tap spacing.
    localparam int MOD_STEPS      = CFG_SPACING_W;

    localparam logic [CFG_TAPS_W-1:0]    RST_TAP_COUNT   = 3'd1;
    localparam logic [CFG_SPACING_W-1:0] RST_TAP_SPACING = 15'd4096;
    localparam logic [CFG_RING_W-1:0]    RST_RING_LENGTH = 15'd16384;
    localparam logic [GAIN_W-1:0]        RST_GAIN_ONE    = 16'd3277;

    localparam logic signed [SAMPLE_W+1:0] CLAMP_POS = 18'sd32767;
    localparam logic signed [SAMPLE_W+1:0] CLAMP_NEG = -18'sd32767;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TAP_COUNT   = 3'd0,
        CFG_TAP_SPACING = 3'd1,
        CFG_RING_LENGTH = 3'd2,
        CFG_GAIN_ONE    = 3'd3,
        CFG_GAIN_TWO    = 3'd4,
        CFG_GAIN_THREE  = 3'd5,
        CFG_GAIN_FOUR   = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_TAP,
        S_DRAIN1,
        S_DRAIN2,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic mod_start;
        logic mod_step;
        logic start;
        logic tap_issue;
        logic finish;
        logic store;
    } t_cmd;

    typedef logic [NUM_GAINS-1:0][GAIN_W-1:0] t_gain_vec;

endpackage

FILE: rtl/mte_ctrl.sv
module mte_ctrl #(
    parameter int MAX_TAPS = mte_pkg::DEF_MAX_TAPS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  logic [mte_pkg::CFG_TAPS_W-1:0] i_tap_count,
    input  logic                           i_cfg_touch,
    input  logic                           i_clear_last,
    output mte_pkg::t_cmd                  o_cmd
);
    import mte_pkg::*;

    localparam int CNT_A = $clog2(MOD_STEPS + 1);
    localparam int CNT_B = $clog2(MAX_TAPS + 1);
    localparam int CNT_W = (CNT_A > CNT_B) ? CNT_A : CNT_B;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_bypass, n_bypass;
    logic             r_mod_ok, n_mod_ok;
    logic             r_out_valid, n_out_valid;
    logic [CNT_W-1:0] w_tc;
    logic [CNT_W-1:0] w_taps;
    t_cmd             w_cmd;

    assign w_tc   = CNT_W'(i_tap_count);
    assign w_taps = (w_tc > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : w_tc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_bypass    <= 1'b0;
            r_mod_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_bypass    <= n_bypass;
            r_mod_ok    <= n_mod_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_bypass    = r_bypass;
        n_mod_ok    = r_mod_ok;
        n_out_valid = r_out_valid && i_out_stall;
        w_cmd       = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_cmd.clear_step = 1'b1;
                if (i_clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!r_mod_ok) begin
                    // The run starts only once a burst of register writes has ended.
                    if (!i_cfg_touch) begin
                        w_cmd.mod_start = 1'b1;
                        n_cnt           = '0;
                        n_state         = S_MOD;
                    end
                end else if (i_in_valid) begin
                    w_cmd.start = 1'b1;
                    n_cnt       = CNT_W'(1);
                    n_bypass    = (w_taps == '0);
                    n_state     = (w_taps == '0) ? S_FINISH : S_TAP;
                end
            end
            S_MOD: begin
                // A register write during the remainder run starts it over.
                if (i_cfg_touch) begin
                    n_state = S_IDLE;
                end else begin
                    w_cmd.mod_step = 1'b1;
                    n_cnt          = r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(MOD_STEPS - 1)) begin
                        n_state  = S_IDLE;
                        n_mod_ok = 1'b1;
                    end
                end
            end
            S_TAP: begin
                w_cmd.tap_issue = 1'b1;
                n_cnt           = r_cnt + CNT_W'(1);
                if (r_cnt == w_taps) begin
                    n_state = S_DRAIN1;
                end
            end
            S_DRAIN1: begin
                n_state = S_DRAIN2;
            end
            S_DRAIN2: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.finish = 1'b1;
                    w_cmd.store  = !r_bypass;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_touch) begin
            n_mod_ok = 1'b0;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_stall  = !((r_state == S_IDLE) && r_mod_ok);
    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINISH))
        else $error("result appeared outside the finish step");

    a_tap_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP) |-> ((r_cnt != '0) && (r_cnt <= w_taps)))
        else $error("tap counter out of range");

    a_taps_need_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP) |-> r_mod_ok)
        else $error("taps issued with a stale tap step");
`endif

endmodule

FILE: rtl/mte_dpath.sv
module mte_dpath #(
    parameter int RING_DEPTH = mte_pkg::DEF_RING_DEPTH,
    parameter int MAX_TAPS   = mte_pkg::DEF_MAX_TAPS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mte_pkg::t_cmd                        i_cmd,
    input  logic signed [mte_pkg::SAMPLE_W-1:0]  i_dry_sample,
    input  logic [mte_pkg::CFG_SPACING_W-1:0]    i_tap_spacing,
    input  logic [mte_pkg::CFG_RING_W-1:0]       i_ring_length,
    input  mte_pkg::t_gain_vec                   i_gain,
    output logic                                 o_clear_last,
    output logic signed [mte_pkg::SAMPLE_W-1:0]  o_wet_sample
);
    import mte_pkg::*;

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int LEN_W  = $clog2(RING_DEPTH + 1);
    localparam int X_W    = ADDR_W + 1;
    localparam int CMP_W  = (LEN_W > CFG_RING_W) ? LEN_W : CFG_RING_W;
    localparam int GS_W   = $clog2(MAX_TAPS + 1);
    localparam int PROD_W = 2 * SAMPLE_W + 1;
    localparam int ACC_W  = SAMPLE_W + 2;

    localparam logic [CMP_W-1:0]  DEPTH_C   = CMP_W'(RING_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RING_DEPTH - 1);

    logic [SAMPLE_W-1:0]             r_ring [RING_DEPTH];
    logic [SAMPLE_W-1:0]             r_rdata;
    logic [ADDR_W-1:0]               r_clr_addr;
    logic [ADDR_W-1:0]               r_wp;
    logic [ADDR_W-1:0]               r_wpx;
    logic [ADDR_W-1:0]               r_d;
    logic [ADDR_W-1:0]               r_rem;
    logic [CFG_SPACING_W-1:0]        r_sh;
    logic [GS_W-1:0]                 r_gsel;
    logic [GAIN_W-1:0]               r_g1;
    logic                            r_v1;
    logic                            r_v2;
    logic signed [PROD_W-1:0]        r_prod;
    logic signed [SAMPLE_W-1:0]      r_acc;
    logic [SAMPLE_W-1:0]             r_dry;
    logic signed [SAMPLE_W-1:0]      r_wet;

    logic [CMP_W-1:0]                w_rl;
    logic [LEN_W-1:0]                w_len;
    logic [X_W-1:0]                  w_len_x;
    logic [X_W-1:0]                  w_rem_t;
    logic [X_W-1:0]                  w_dsum;
    logic [X_W-1:0]                  w_wp_inc;
    logic [ADDR_W-1:0]               w_rd_addr;
    logic [GAIN_W-1:0]               w_gain;
    logic signed [PROD_W-1:0]        w_prod;
    logic signed [PROD_W-1:0]        w_biased;
    logic signed [SAMPLE_W:0]        w_scaled;
    logic signed [ACC_W-1:0]         w_sum;
    logic signed [SAMPLE_W-1:0]      w_clamped;

    // Effective ring length: zero acts as one, and it never exceeds the store.
    assign w_rl = CMP_W'(i_ring_length);
    always_comb begin
        if (w_rl == '0) begin
            w_len = LEN_W'(1);
        end else if (w_rl > DEPTH_C) begin
            w_len = LEN_W'(RING_DEPTH);
        end else begin
            w_len = LEN_W'(w_rl);
        end
    end
    assign w_len_x = X_W'(w_len);

    // Restoring remainder step: tap spacing modulo ring length, one bit a cycle.
    always_comb begin
        w_rem_t = {r_rem, r_sh[CFG_SPACING_W-1]};
        if (w_rem_t >= w_len_x) begin
            w_rem_t = w_rem_t - w_len_x;
        end
    end

    assign w_dsum    = X_W'(r_d) + X_W'(r_rem);
    assign w_wp_inc  = X_W'(r_wpx) + X_W'(1);
    assign w_rd_addr = (r_wpx >= r_d) ? (r_wpx - r_d)
                                      : ADDR_W'(X_W'(r_wpx) + w_len_x - X_W'(r_d));

    always_comb begin
        w_gain = '0;
        for (int k = 0; k < NUM_GAINS; k++) begin
            if (32'(r_gsel) == k) begin
                w_gain = i_gain[k];
            end
        end
    end

    assign w_prod = $signed(r_rdata) * $signed({1'b0, r_g1});

    // Truncation toward zero: negative products get a bias before the shift.
    assign w_biased = r_prod + (r_prod[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
    assign w_scaled = w_biased[PROD_W-1:SAMPLE_W];
    assign w_sum    = ACC_W'(r_acc) + ACC_W'(w_scaled);

    always_comb begin
        if (w_sum > CLAMP_POS) begin
            w_clamped = SAMPLE_W'(CLAMP_POS);
        end else if (w_sum < CLAMP_NEG) begin
            w_clamped = SAMPLE_W'(CLAMP_NEG);
        end else begin
            w_clamped = SAMPLE_W'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_wp       <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.store) begin
                r_wp <= (w_wp_inc >= w_len_x) ? '0 : ADDR_W'(w_wp_inc);
            end
            r_v1 <= i_cmd.tap_issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_ring[r_clr_addr] <= '0;
        end else if (i_cmd.store) begin
            r_ring[r_wpx] <= r_dry;
        end
        if (i_cmd.tap_issue) begin
            r_rdata <= r_ring[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_start) begin
            r_rem <= '0;
            r_sh  <= i_tap_spacing;
        end else if (i_cmd.mod_step) begin
            r_rem <= ADDR_W'(w_rem_t);
            r_sh  <= r_sh << 1;
        end

        if (i_cmd.start) begin
            r_dry  <= i_dry_sample;
            r_acc  <= i_dry_sample;
            r_wpx  <= (X_W'(r_wp) >= w_len_x) ? '0 : r_wp;
            r_d    <= r_rem;
            r_gsel <= '0;
        end else begin
            if (i_cmd.tap_issue) begin
                r_d    <= (w_dsum >= w_len_x) ? ADDR_W'(w_dsum - w_len_x) : ADDR_W'(w_dsum);
                r_gsel <= r_gsel + GS_W'(1);
            end
            if (r_v2) begin
                r_acc <= w_clamped;
            end
        end

        if (i_cmd.tap_issue) begin
            r_g1 <= w_gain;
        end
        if (r_v1) begin
            r_prod <= w_prod;
        end
        if (i_cmd.finish) begin
            r_wet <= r_acc;
        end
    end

    assign o_clear_last = (r_clr_addr == LAST_ADDR);
    assign o_wet_sample = r_wet;

`ifndef NO_ASSERTIONS
    a_dist_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tap_issue |-> (X_W'(r_d) < w_len_x))
        else $error("tap distance not reduced below the ring length");

    a_wp_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> (X_W'(r_wpx) < w_len_x))
        else $error("write pointer beyond the ring length");

    a_acc_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |=> (r_acc != 16'sh8000))
        else $error("echo sum left the symmetric range");
`endif

endmodule

FILE: rtl/multi_tap_echo.sv
// Multi-tap echo. Each transaction on the input channel carries one signed
// 16-bit sample and yields exactly one wet sample on the output channel: the
// dry sample plus each tap's history sample (j*tap_spacing back in a circular
// store) scaled by its Q0.16 gain, clamped to +-32767 after every tap. An item
// is processed by one read a cycle from the single-ported history memory into
// a three-stage multiply and accumulate, then the store of the dry sample; a
// bypass item (tap_count of zero) skips the taps and the store. After reset a
// clearing pass writes zero to all RING_DEPTH entries, one a cycle, and any
// register write is followed by a remainder run over the bits of tap_spacing
// that computes the tap step; no input is taken during either, while register
// writes are accepted at any time the block is idle.
// A finished result waits in the output register while the next input is
// already being taken.
module multi_tap_echo #(
    parameter int RING_DEPTH = mte_pkg::DEF_RING_DEPTH,
    parameter int MAX_TAPS   = mte_pkg::DEF_MAX_TAPS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [mte_pkg::SAMPLE_W-1:0]   i_dry_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [mte_pkg::SAMPLE_W-1:0]   o_wet_sample,
    input  logic                                  i_cfg_we,
    input  logic [mte_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [mte_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import mte_pkg::*;

    logic [CFG_TAPS_W-1:0]    r_tap_count;
    logic [CFG_SPACING_W-1:0] r_tap_spacing;
    logic [CFG_RING_W-1:0]    r_ring_length;
    t_gain_vec                r_gain;
    t_cmd                     w_cmd;
    logic                     w_clear_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count   <= RST_TAP_COUNT;
            r_tap_spacing <= RST_TAP_SPACING;
            r_ring_length <= RST_RING_LENGTH;
            r_gain        <= {{((NUM_GAINS - 1) * GAIN_W){1'b0}}, RST_GAIN_ONE};
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TAP_COUNT:   r_tap_count   <= i_cfg_data[CFG_TAPS_W-1:0];
                CFG_TAP_SPACING: r_tap_spacing <= i_cfg_data[CFG_SPACING_W-1:0];
                CFG_RING_LENGTH: r_ring_length <= i_cfg_data[CFG_RING_W-1:0];
                CFG_GAIN_ONE:    r_gain[0]     <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_TWO:    r_gain[1]     <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_THREE:  r_gain[2]     <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_FOUR:   r_gain[3]     <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mte_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_tap_count  (r_tap_count),
        .i_cfg_touch  (i_cfg_we),
        .i_clear_last (w_clear_last),
        .o_cmd        (w_cmd)
    );

    mte_dpath #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_TAPS   (MAX_TAPS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_dry_sample  (i_dry_sample),
        .i_tap_spacing (r_tap_spacing),
        .i_ring_length (r_ring_length),
        .i_gain        (r_gain),
        .o_clear_last  (w_clear_last),
        .o_wet_sample  (o_wet_sample)
    );

endmodule

FILE: tb/tb_multi_tap_echo.sv
module tb_multi_tap_echo;
    timeunit 1ns;
    timeprecision 1ps;

    import mte_pkg::*;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic signed [SAMPLE_W-1:0] i_dry_sample = '0;
    logic                       i_out_stall = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic signed [SAMPLE_W-1:0] o_wet_sample;

    multi_tap_echo dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_dry_sample (i_dry_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_wet_sample (o_wet_sample),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Predictor copy of the history store, write pointer and registers.
    logic signed [SAMPLE_W-1:0]      echo_hist [DEF_RING_DEPTH];
    int unsigned                     hist_ptr;
    logic [CFG_TAPS_W-1:0]           set_taps;
    logic [CFG_SPACING_W-1:0]        set_spacing;
    logic [CFG_RING_W-1:0]           set_ring;
    logic [GAIN_W-1:0]               set_gain [NUM_GAINS];

    logic signed [SAMPLE_W-1:0]      dry_queue [$];
    logic signed [SAMPLE_W-1:0]      wet_expected [$];
    logic signed [SAMPLE_W-1:0]      wet_oldest;
    int unsigned                     dry_sent = 0;
    int unsigned                     wet_seen = 0;
    int unsigned                     fails = 0;
    int unsigned                     hold_left = 0;
    logic                            hold_done = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Computes the wet sample for one dry sample and, unless in bypass, updates the history.
    function automatic logic signed [SAMPLE_W-1:0] echo_sample(logic signed [SAMPLE_W-1:0] dry);
        int unsigned taps;
        int unsigned len;
        int unsigned wp;
        int unsigned tap_dist;
        int unsigned idx;
        longint      acc;
        longint      scaled;
        if (set_taps == 0) begin
            return dry;
        end
        taps = (set_taps > DEF_MAX_TAPS) ? DEF_MAX_TAPS : set_taps;
        len = set_ring;
        if (len == 0) len = 1;
        if (len > DEF_RING_DEPTH) len = DEF_RING_DEPTH;
        wp = (hist_ptr >= len) ? 0 : hist_ptr;
        acc = dry;
        for (int unsigned j = 1; j <= taps; j++) begin
            tap_dist = (j * set_spacing) % len;
            idx = (wp + len - tap_dist) % len;
            scaled = (longint'(echo_hist[idx]) * longint'({48'd0, set_gain[j-1]})) / 65536;
            acc = acc + scaled;
            if (acc > 32767) acc = 32767;
            if (acc < -32767) acc = -32767;
        end
        echo_hist[wp] = dry;
        wp++;
        if (wp >= len) wp = 0;
        hist_ptr = wp;
        return acc[SAMPLE_W-1:0];
    endfunction

    // Sender: offers samples from the queue and predicts each accepted one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || !o_in_stall) begin
                if (i_in_valid) begin
                    wet_expected.push_back(echo_sample(i_dry_sample));
                    dry_sent++;
                end
                if (dry_queue.size() != 0 &&
                    ((dry_sent >= 700 && dry_sent < 1000) || $urandom_range(99) >= 16)) begin
                    i_in_valid   <= 1'b1;
                    i_dry_sample <= dry_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each wet sample and drives the output stall.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                wet_seen++;
                if (wet_expected.size() == 0) begin
                    $error("unexpected transaction: wet_sample actual %0d", o_wet_sample);
                    fails++;
                end else begin
                    wet_oldest = wet_expected.pop_front();
                    if (o_wet_sample !== wet_oldest) begin
                        $error("wet_sample expected %0d actual %0d", wet_oldest, o_wet_sample);
                        fails++;
                    end
                end
            end
            // One long hold-off lets the block fill up and stall its input.
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!hold_done && wet_seen >= 300) begin
                hold_done = 1'b1;
                hold_left = 400;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !(wet_seen >= 700 && wet_seen < 1000) &&
                               ($urandom_range(99) < 16);
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TAP_COUNT:   set_taps    = value[CFG_TAPS_W-1:0];
            CFG_TAP_SPACING: set_spacing = value[CFG_SPACING_W-1:0];
            CFG_RING_LENGTH: set_ring    = value[CFG_RING_W-1:0];
            CFG_GAIN_ONE:    set_gain[0] = value;
            CFG_GAIN_TWO:    set_gain[1] = value;
            CFG_GAIN_THREE:  set_gain[2] = value;
            CFG_GAIN_FOUR:   set_gain[3] = value;
            default: ;
        endcase
        // Leave room for the remainder run that follows every write.
        repeat (20) @(posedge i_clk);
    endtask

    task automatic load_settings(int unsigned taps, int unsigned spacing, int unsigned ring,
                                 int unsigned g1, int unsigned g2, int unsigned g3,
                                 int unsigned g4);
        write_reg(CFG_TAP_COUNT, 16'(taps));
        write_reg(CFG_TAP_SPACING, 16'(spacing));
        write_reg(CFG_RING_LENGTH, 16'(ring));
        write_reg(CFG_GAIN_ONE, 16'(g1));
        write_reg(CFG_GAIN_TWO, 16'(g2));
        write_reg(CFG_GAIN_THREE, 16'(g3));
        write_reg(CFG_GAIN_FOUR, 16'(g4));
    endtask

    // Queues a batch, then waits until every wet sample is back and the block is quiet.
    task automatic offer_batch(logic signed [SAMPLE_W-1:0] batch [$]);
        @(negedge i_clk);
        foreach (batch[k]) dry_queue.push_back(batch[k]);
        do @(negedge i_clk);
        while (dry_queue.size() != 0 || i_in_valid || wet_expected.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_phase(int unsigned count);
        int unsigned                taps;
        int unsigned                spacing;
        int unsigned                ring;
        int unsigned                n;
        int unsigned                g [NUM_GAINS];
        logic signed [SAMPLE_W-1:0] batch [$];
        taps = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(1, 4);
        ring = ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(1, 64);
        spacing = ($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(0, ring + 2);
        n = (taps == 0) ? 1 : ((taps > NUM_GAINS) ? NUM_GAINS : taps);
        for (int j = 0; j < NUM_GAINS; j++) begin
            case ($urandom_range(2))
                0: begin
                    // Rounded gains, with 0.05 on the last tap.
                    if (j == n - 1) g[j] = 3277;
                    else if (j < n) g[j] = ((131072 * n) / ((n + 1) * (j + 1) * 4) + 1) / 2;
                    else g[j] = 0;
                end
                1: g[j] = $urandom_range(65535);
                default: g[j] = $urandom_range(1) ? 65535 : 0;
            endcase
        end
        load_settings(taps, spacing, ring, g[0], g[1], g[2], g[3]);
        repeat (count) begin
            case ($urandom_range(15))
                0: batch.push_back(16'sh7FFF);
                1: batch.push_back(16'sh8000);
                default: batch.push_back(SAMPLE_W'($urandom));
            endcase
        end
        offer_batch(batch);
    endtask

    initial begin
        foreach (echo_hist[k]) echo_hist[k] = '0;
        hist_ptr    = 0;
        set_taps    = RST_TAP_COUNT;
        set_spacing = RST_TAP_SPACING;
        set_ring    = RST_RING_LENGTH;
        set_gain[0] = RST_GAIN_ONE;
        set_gain[1] = '0;
        set_gain[2] = '0;
        set_gain[3] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings first; these items also wait out the clearing pass.
        offer_batch('{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh5555});
        // Full gains on a short ring drive the sum into both clamps.
        load_settings(4, 1, 4, 65535, 65535, 65535, 65535);
        offer_batch('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                      16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        // Bypass passes even the most negative sample through.
        load_settings(0, 3, 16, 100, 200, 300, 400);
        offer_batch('{16'sh8000, 16'sh7FFF, 16'sh3039});
        // Ring length above the store depth.
        load_settings(3, 5, 32767, 32768, 65535, 1, 0);
        offer_batch('{16'sh1234, 16'shAAAA, 16'sh8000, 16'sh7FFF});
        // Too many taps, zero spacing, zero ring and a pointer past the new ring.
        load_settings(7, 0, 0, 13107, 6554, 4369, 3277);
        offer_batch('{16'sh1234, 16'sh8000, 16'sh7FFF, 16'shAAAA});

        repeat (10) random_phase(180);

        if (fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
